// ----- sv/lscemb_pkg.sv -----
// lscemb_pkg: shared types and constants for the lsb stego channel embedder
// word layouts for the input and result channels, queue entry, codes
// no dependencies
package lscemb_pkg;

  // header layout: 4-bit setting then 24-bit length, two bits per channel
  localparam int HDR_CHANNELS = 14;
  localparam int HDR_BITS     = 28;
  localparam int LEN_BITS     = 24;
  localparam int MB_W         = 14;

  // saturation limit of the channel counter and bit pointer
  localparam logic [13:0] CNT_MAX = 14'h3FFF;

  // legal range of bits per channel
  localparam logic [3:0] BPC_MIN = 4'd1;
  localparam logic [3:0] BPC_MAX = 4'd8;

  // input word action codes
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // result region codes
  localparam logic [1:0] REGION_HEADER = 2'd0;
  localparam logic [1:0] REGION_DATA   = 2'd1;
  localparam logic [1:0] REGION_PASS   = 2'd2;

  // register index, taken from paddr bit 2
  localparam logic REG_BPC      = 1'b0;
  localparam logic REG_MSG_BITS = 1'b1;

  typedef struct packed {
    logic       action;
    logic [9:0] byte_index;
    logic [7:0] message_byte;
    logic [7:0] channel_sample;
    logic       first_sample;
  } in_item_t;

  typedef struct packed {
    logic [7:0] encoded_sample;
    logic [1:0] region;
  } out_item_t;

  // classified sample, built by the front end
  typedef struct packed {
    logic [7:0] sample;
    logic [1:0] region;
    logic [7:0] keep_mask;
    logic [1:0] hdr_bits;
    logic [7:0] data_en;
    logic [2:0] bit_off;
  } desc_t;

  // queue entry: descriptor plus the two message bytes the group spans
  typedef struct packed {
    desc_t      desc;
    logic [7:0] byte_lo;
    logic [7:0] byte_hi;
  } q_entry_t;

endpackage

// ----- sv/lscemb_front.sv -----
// lscemb_front: accepts input words, holds the message store, classifies samples
// depends on lscemb_pkg
// feeds lscemb_queue with one entry per sample, in the cycle after acceptance
module lscemb_front #(
  parameter int MSG_BYTES = 1024,
  parameter int DEPTH     = 4,
  parameter int CW        = 3
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  lscemb_pkg::in_item_t   in_data,
  input  logic [3:0]             cfg_bpc,
  input  logic [13:0]            cfg_msg_bits,
  input  logic [CW-1:0]          q_level,
  output logic                   push,
  output lscemb_pkg::q_entry_t   push_entry
);

  localparam int AW = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
  localparam int PW = ((AW > 11) ? AW : 11) + 1;
  localparam int SW = CW + 1;

  logic [13:0]         cc_r, cc_nxt, ptr_r, ptr_nxt;
  logic [13:0]         cc_cur, ptr_cur;
  logic                s1_valid_r;
  lscemb_pkg::desc_t   s1_desc_r, desc_nxt;
  logic [7:0]          rd_lo_r, rd_hi_r;
  logic [7:0]          mem [MSG_BYTES];
  logic [SW-1:0]       used;
  logic                accept, sample_acc, load_acc;
  logic [3:0]          bpc_eff;
  logic [31:0]         hdr_word;
  logic [4:0]          hdr_idx;
  logic                is_hdr, is_data;
  logic [7:0]          n_mask, data_en;
  logic [PW-1:0]       b_lo, b_hi, idx_w;
  logic                lo_ok, hi_ok, idx_ok;
  logic [14:0]         ptr_sum;

  // credit check: queue entries plus the one in flight
  assign used       = SW'(q_level) + SW'(s1_valid_r);
  assign in_stall   = (used >= SW'(DEPTH));
  assign accept     = in_valid & ~in_stall;
  assign sample_acc = accept & (in_data.action == lscemb_pkg::ACT_SAMPLE);
  assign load_acc   = accept & (in_data.action == lscemb_pkg::ACT_LOAD);

  // clamp the setting
  assign bpc_eff = (cfg_bpc < lscemb_pkg::BPC_MIN) ? lscemb_pkg::BPC_MIN :
                   (cfg_bpc > lscemb_pkg::BPC_MAX) ? lscemb_pkg::BPC_MAX : cfg_bpc;

  // counters as seen by this sample
  assign cc_cur  = in_data.first_sample ? '0 : cc_r;
  assign ptr_cur = in_data.first_sample ? '0 : ptr_r;

  // header word, msb first from bit 27
  assign hdr_word = {4'b0, bpc_eff, {(lscemb_pkg::LEN_BITS - lscemb_pkg::MB_W){1'b0}},
                     cfg_msg_bits};
  assign hdr_idx  = 5'(lscemb_pkg::HDR_BITS - 1) - {cc_cur[3:0], 1'b0};

  assign is_hdr  = (cc_cur < 14'(lscemb_pkg::HDR_CHANNELS));
  assign is_data = ~is_hdr & (ptr_cur < cfg_msg_bits);
  assign n_mask  = 8'hFF >> (4'd8 - bpc_eff);

  // message bytes covered by the group
  assign b_lo   = PW'(ptr_cur >> 3);
  assign b_hi   = b_lo + PW'(1);
  assign lo_ok  = (b_lo < PW'(MSG_BYTES));
  assign hi_ok  = (b_hi < PW'(MSG_BYTES));
  assign idx_w  = PW'(in_data.byte_index);
  assign idx_ok = (idx_w < PW'(MSG_BYTES));

  // per-bit enables: inside the message length and inside the store
  always_comb begin
    logic [14:0] pos;
    logic [3:0]  sft;
    pos = '0;
    sft = '0;
    for (int j = 0; j < 8; j++) begin
      pos        = {1'b0, ptr_cur} + 15'(j);
      sft        = {1'b0, ptr_cur[2:0]} + 4'(j);
      data_en[j] = (pos < {1'b0, cfg_msg_bits}) & (sft[3] ? hi_ok : lo_ok);
    end
  end

  // descriptor and next counter values
  always_comb begin
    desc_nxt.sample   = in_data.channel_sample;
    desc_nxt.data_en  = data_en;
    desc_nxt.bit_off  = ptr_cur[2:0];
    desc_nxt.hdr_bits = {hdr_word[hdr_idx - 5'd1], hdr_word[hdr_idx]};
    if (is_hdr) begin
      desc_nxt.region    = lscemb_pkg::REGION_HEADER;
      desc_nxt.keep_mask = 8'h03;
    end else if (is_data) begin
      desc_nxt.region    = lscemb_pkg::REGION_DATA;
      desc_nxt.keep_mask = n_mask;
    end else begin
      desc_nxt.region    = lscemb_pkg::REGION_PASS;
      desc_nxt.keep_mask = 8'h00;
    end
    ptr_sum = {1'b0, ptr_cur} + 15'(bpc_eff);
    if (!is_data) begin
      ptr_nxt = ptr_cur;
    end else if (ptr_sum > {1'b0, lscemb_pkg::CNT_MAX}) begin
      ptr_nxt = lscemb_pkg::CNT_MAX;
    end else begin
      ptr_nxt = ptr_sum[13:0];
    end
    cc_nxt = (cc_cur == lscemb_pkg::CNT_MAX) ? cc_cur : cc_cur + 14'd1;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r       <= '0;
      ptr_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= sample_acc;
      if (sample_acc) begin
        cc_r  <= cc_nxt;
        ptr_r <= ptr_nxt;
      end
    end
  end

  // descriptor register
  always_ff @(posedge clk) begin
    if (sample_acc) begin
      s1_desc_r <= desc_nxt;
    end
  end

  // message store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (load_acc && idx_ok) begin
      mem[idx_w[AW-1:0]] <= in_data.message_byte;
    end
    if (sample_acc) begin
      rd_lo_r <= mem[b_lo[AW-1:0]];
      rd_hi_r <= mem[b_hi[AW-1:0]];
    end
  end

  assign push               = s1_valid_r;
  assign push_entry.desc    = s1_desc_r;
  assign push_entry.byte_lo = rd_lo_r;
  assign push_entry.byte_hi = rd_hi_r;

endmodule

// ----- sv/lscemb_queue.sv -----
// lscemb_queue: short fifo of classified samples between front and back end
// depends on lscemb_pkg
module lscemb_queue #(
  parameter int DEPTH = 4,
  parameter int CW    = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  lscemb_pkg::q_entry_t  push_entry,
  input  logic                  pop,
  output lscemb_pkg::q_entry_t  head,
  output logic [CW-1:0]         level
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  lscemb_pkg::q_entry_t  slot_r [DEPTH];
  logic [PTRW-1:0]       wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]         count_r;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_r + PTRW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_r + PTRW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  assign head  = slot_r[rd_ptr_r];
  assign level = count_r;

  // credit scheme never overfills the queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> count_r != CW'(DEPTH))
    else $error("queue push while full");

  // back end never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("queue pop while empty");

  // fill count rises by one on a push without a pop
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + CW'(1))
    else $error("queue count out of step");

endmodule

// ----- sv/lscemb_back.sv -----
// lscemb_back: merges header or message bits into the sample or passes it through, drives result word
// depends on lscemb_pkg; pops lscemb_queue
module lscemb_back #(
  parameter int CW = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lscemb_pkg::q_entry_t  head,
  input  logic [CW-1:0]         q_level,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lscemb_pkg::out_item_t out_data
);

  logic                   out_valid_r;
  lscemb_pkg::out_item_t  out_data_r, res_nxt;
  logic [15:0]            stream;
  logic [7:0]             mbits, bits;

  // two bytes as one msb-first bit stream
  assign stream = {head.byte_lo, head.byte_hi};

  // message group, first bit into bit 0
  always_comb begin
    logic [3:0] k;
    k = '0;
    for (int j = 0; j < 8; j++) begin
      k        = {1'b0, head.desc.bit_off} + 4'(j);
      mbits[j] = head.desc.data_en[j] & stream[4'd15 - k];
    end
  end

  assign bits = (head.desc.region == lscemb_pkg::REGION_DATA) ? mbits :
                {6'b0, head.desc.hdr_bits};

  // replace the low bits
  always_comb begin
    res_nxt.encoded_sample = (head.desc.sample & ~head.desc.keep_mask) |
                             (bits & head.desc.keep_mask);
    res_nxt.region         = head.desc.region;
  end

  assign pop = (q_level != '0) & (~out_valid_r | ~out_stall);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= (q_level != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- sv/lsb_stego_channel_embedder_unit.sv -----
// lsb_stego_channel_embedder_unit: top level, register file and module wiring
// depends on lscemb_pkg, lscemb_front, lscemb_queue, lscemb_back
//
//   port group   direction   word / width            handshake
//   in_*         input       lscemb_pkg::in_item_t   in_valid / in_stall
//   out_*        output      lscemb_pkg::out_item_t  out_valid / out_stall
//   apb          input       32-bit, paddr[2:0]      psel / penable, pready tied high
//
// one word per clock while in_stall is low; a sample result passes through the store
// read, the queue and the output register after acceptance, loads give no result
// the message store read is registered, set by its two read ports
// reset is synchronous, active low, clears counters, queue and output valid
// in_stall rises when the queue plus the in-flight entry fill it;
// the queue absorbs out_stall so the front keeps taking words until the queue fills
module lsb_stego_channel_embedder_unit #(
  parameter int MSG_BYTES   = 1024,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  lscemb_pkg::in_item_t   in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output lscemb_pkg::out_item_t  out_data,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [3:0]            bpc_r;
  logic [13:0]           msg_bits_r;
  logic                  cfg_wr;
  logic                  push, pop;
  lscemb_pkg::q_entry_t  push_entry, head;
  logic [CW-1:0]         q_level;

  // register file
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpc_r      <= 4'd1;
      msg_bits_r <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == lscemb_pkg::REG_BPC) begin
        bpc_r <= pwdata[3:0];
      end else begin
        msg_bits_r <= pwdata[13:0];
      end
    end
  end

  // read mux
  always_comb begin
    case (paddr[2])
      lscemb_pkg::REG_BPC:      prdata = {28'b0, bpc_r};
      lscemb_pkg::REG_MSG_BITS: prdata = {18'b0, msg_bits_r};
      default:                  prdata = '0;
    endcase
  end

  lscemb_front #(
    .MSG_BYTES (MSG_BYTES),
    .DEPTH     (QUEUE_DEPTH),
    .CW        (CW)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .cfg_bpc      (bpc_r),
    .cfg_msg_bits (msg_bits_r),
    .q_level      (q_level),
    .push         (push),
    .push_entry   (push_entry)
  );

  lscemb_queue #(
    .DEPTH (QUEUE_DEPTH),
    .CW    (CW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .level      (q_level)
  );

  lscemb_back #(
    .CW (CW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_level   (q_level),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- bench/lsb_stego_channel_embedder_unit_test.sv -----
// lsb_stego_channel_embedder_unit_test: self-checking bench for the lsb stego embedder
// holds a scoreboard class with its own embedding predictor plus the driving tasks
// depends on lscemb_pkg and lsb_stego_channel_embedder_unit

// tracks message store, channel count and bit pointer, and queues predicted samples
class embed_checker;
  logic [7:0]  msg_mem [1024];
  logic [13:0] chan_cnt;
  logic [13:0] bit_ptr;
  logic [3:0]  bpc_reg;
  logic [13:0] len_reg;
  lscemb_pkg::out_item_t pending_samples[$];
  int unsigned fails;
  int unsigned loads;
  int unsigned hdr_cnt;
  int unsigned data_cnt;
  int unsigned pass_cnt;

  function new();
    foreach (msg_mem[i]) msg_mem[i] = 8'h00;
    chan_cnt = '0;
    bit_ptr  = '0;
    bpc_reg  = 4'd1;
    len_reg  = '0;
    fails    = 0;
    loads    = 0;
    hdr_cnt  = 0;
    data_cnt = 0;
    pass_cnt = 0;
  endfunction

  function void flag(string msg);
    fails++;
    if (fails <= 10) $display("mismatch: %s", msg);
  endfunction

  function void set_reg(logic sel, logic [31:0] value);
    if (sel == lscemb_pkg::REG_BPC) bpc_reg = value[3:0];
    else len_reg = value[13:0];
  endfunction

  // setting clamped to 1..8
  function int unsigned group_width();
    if (bpc_reg < lscemb_pkg::BPC_MIN) return 1;
    if (bpc_reg > lscemb_pkg::BPC_MAX) return 8;
    return bpc_reg;
  endfunction

  // header bit i: 4-bit setting then 24-bit length, msb first
  function bit header_bit(int unsigned i);
    int unsigned len32;
    len32 = len_reg;
    if (i < 4) return 1'((group_width() >> (3 - i)) & 1);
    return 1'((len32 >> (lscemb_pkg::LEN_BITS - 1 - (i - 4))) & 1);
  endfunction

  // message bit at pos, zero past the length or past the store
  function bit stream_bit(int unsigned pos);
    if (pos >= len_reg) return 1'b0;
    if ((pos >> 3) >= 1024) return 1'b0;
    return msg_mem[pos >> 3][7 - (pos & 7)];
  endfunction

  // accepted input word: update state, queue the predicted sample
  function void take_word(lscemb_pkg::in_item_t w);
    lscemb_pkg::out_item_t pred;
    int unsigned n;
    int unsigned ptr;
    logic [7:0]  bits;
    logic [7:0]  mask;
    logic [1:0]  region;
    if (w.action == lscemb_pkg::ACT_LOAD) begin
      msg_mem[w.byte_index] = w.message_byte;
      loads++;
      return;
    end
    if (w.first_sample) begin
      chan_cnt = '0;
      bit_ptr  = '0;
    end
    bits = '0;
    if (chan_cnt < lscemb_pkg::HDR_CHANNELS) begin
      n = 2;
      for (int j = 0; j < 2; j++) bits[j] = header_bit(int'(chan_cnt) * 2 + j);
      region = lscemb_pkg::REGION_HEADER;
      hdr_cnt++;
    end else if (bit_ptr < len_reg) begin
      n = group_width();
      for (int j = 0; j < n; j++) bits[j] = stream_bit(int'(bit_ptr) + j);
      ptr = int'(bit_ptr) + n;
      bit_ptr = (ptr > lscemb_pkg::CNT_MAX) ? lscemb_pkg::CNT_MAX : ptr[13:0];
      region = lscemb_pkg::REGION_DATA;
      data_cnt++;
    end else begin
      n = 0;
      region = lscemb_pkg::REGION_PASS;
      pass_cnt++;
    end
    mask = 8'((1 << n) - 1);
    pred.encoded_sample = (w.channel_sample & ~mask) | (bits & mask);
    pred.region = region;
    if (chan_cnt < lscemb_pkg::CNT_MAX) chan_cnt++;
    pending_samples.push_back(pred);
  endfunction

  // accepted result word: compare with the oldest prediction
  function void check_word(lscemb_pkg::out_item_t got);
    lscemb_pkg::out_item_t want;
    if (pending_samples.size() == 0) begin
      flag($sformatf("result sample %02h region %0d with no sample pending",
                     got.encoded_sample, got.region));
      return;
    end
    want = pending_samples.pop_front();
    if (got.encoded_sample !== want.encoded_sample)
      flag($sformatf("encoded_sample expected %02h got %02h",
                     want.encoded_sample, got.encoded_sample));
    if (got.region !== want.region)
      flag($sformatf("region expected %0d got %0d", want.region, got.region));
  endfunction
endclass

module lsb_stego_channel_embedder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int FILL_BYTES    = 32;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  lscemb_pkg::in_item_t  in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  lscemb_pkg::out_item_t out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;
  int unsigned quiet      = 0;
  int unsigned words_sent = 0;
  int unsigned reg_writes = 0;
  logic [3:0]  cur_bpc    = 4'd1;
  logic [13:0] cur_len    = '0;

  embed_checker chk;

  lsb_stego_channel_embedder_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) chk.check_word(out_data);
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("** lsb_stego_channel_embedder_unit: FAILED **");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic lscemb_pkg::in_item_t make_word(logic act, logic [9:0] idx,
                                                     logic [7:0] mb, logic [7:0] smp,
                                                     logic first);
    lscemb_pkg::in_item_t w;
    w.action         = act;
    w.byte_index     = idx;
    w.message_byte   = mb;
    w.channel_sample = smp;
    w.first_sample   = first;
    return w;
  endfunction

  // offer one word, with random idle cycles ahead of it
  task automatic send_word(lscemb_pkg::in_item_t w);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chk.take_word(w);
    words_sent++;
  endtask

  task automatic send_load(logic [9:0] idx, logic [7:0] mb);
    send_word(make_word(lscemb_pkg::ACT_LOAD, idx, mb, 8'($urandom), 1'($urandom)));
  endtask

  task automatic send_sample(logic [7:0] smp, logic first);
    send_word(make_word(lscemb_pkg::ACT_SAMPLE, 10'($urandom), 8'($urandom), smp, first));
  endtask

  // hold the sender until every predicted sample has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chk.pending_samples.size() != 0) @(posedge clk);
  endtask

  task automatic apb_cycle(logic wr, logic sel, logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {sel, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // register write while idle, then read it back
  task automatic write_reg(logic sel, logic [31:0] value);
    logic [31:0] rb;
    logic [31:0] width_mask;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_cycle(1'b1, sel, value, rb);
    chk.set_reg(sel, value);
    reg_writes++;
    @(posedge clk);
    apb_cycle(1'b0, sel, 32'h0, rb);
    width_mask = (sel == lscemb_pkg::REG_BPC) ? 32'hF : 32'h3FFF;
    if ((rb & width_mask) !== (value & width_mask))
      chk.flag($sformatf("register %0d read back %08h, wrote %08h", sel, rb, value));
    if (sel == lscemb_pkg::REG_BPC) cur_bpc = value[3:0];
    else cur_len = value[13:0];
  endtask

  // one image: header, data groups, then some passthrough; noisy ones get
  // stray loads, stray restarts and may stop early
  task automatic run_image(int unsigned extra, bit restart, bit noisy);
    int unsigned eff;
    int unsigned total;
    logic        first;
    eff = (cur_bpc < lscemb_pkg::BPC_MIN) ? 1 : (cur_bpc > lscemb_pkg::BPC_MAX) ? 8 : cur_bpc;
    total = lscemb_pkg::HDR_CHANNELS + (cur_len + eff - 1) / eff + extra;
    for (int unsigned i = 0; i < total; i++) begin
      if (noisy && $urandom_range(0, 19) == 0) send_load(10'($urandom), 8'($urandom));
      if (noisy && $urandom_range(0, 99) == 0) break;
      first = (i == 0 && restart) || (noisy && $urandom_range(0, 49) == 0);
      send_sample(8'($urandom), first);
    end
  endtask

  function automatic logic [3:0] pick_bpc();
    case ($urandom_range(0, 4))
      0: return 4'd0;
      1: return 4'd1;
      2: return 4'd8;
      3: return 4'd15;
      default: return 4'($urandom);
    endcase
  endfunction

  // random traffic: settings, loads and images until the word count is reached
  task automatic run_phase(int unsigned words);
    int unsigned start;
    start = words_sent;
    while (words_sent - start < words) begin
      case ($urandom_range(0, 3))
        0: write_reg(lscemb_pkg::REG_BPC, {28'h0, pick_bpc()});
        1: write_reg(lscemb_pkg::REG_MSG_BITS,
                     ($urandom_range(0, 7) == 0) ? $urandom_range(0, 200)
                                                 : $urandom_range(0, 32));
        default: ;
      endcase
      repeat ($urandom_range(0, 3)) send_load(10'($urandom), 8'($urandom));
      run_image($urandom_range(0, 6), $urandom_range(0, 9) != 0, $urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) == 0) drain();
    end
  endtask

  initial begin
    chk = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the low store bytes so every message read hits a written entry
    for (int i = 0; i < FILL_BYTES; i++) send_load(10'(i), 8'($urandom));

    // directed: setting 0 acting as 1, loads ignoring first_sample, short image
    write_reg(lscemb_pkg::REG_BPC, 32'd0);
    write_reg(lscemb_pkg::REG_MSG_BITS, 32'd3);
    send_word(make_word(lscemb_pkg::ACT_LOAD, 10'd0, 8'hA5, 8'h00, 1'b1));
    send_word(make_word(lscemb_pkg::ACT_LOAD, 10'h3FF, 8'hFF, 8'hFF, 1'b0));
    send_word(make_word(lscemb_pkg::ACT_SAMPLE, 10'h3FF, 8'hFF, 8'hFF, 1'b1));
    for (int i = 1; i < 14; i++) send_sample((i % 2) ? 8'h00 : 8'hFF, 1'b0);
    for (int i = 0; i < 5; i++) send_sample((i % 2) ? 8'hFF : 8'h00, 1'b0);

    // setting 15 acting as 8 with a message over the whole filled area
    write_reg(lscemb_pkg::REG_BPC, 32'd15);
    write_reg(lscemb_pkg::REG_MSG_BITS, 32'(FILL_BYTES * 8));
    run_image(4, 1'b1, 1'b0);

    // full length register in the header, data kept inside the filled bytes
    write_reg(lscemb_pkg::REG_MSG_BITS, 32'h3FFF);
    for (int i = 0; i < lscemb_pkg::HDR_CHANNELS + FILL_BYTES; i++)
      send_sample(8'($urandom), i == 0);

    // random phases with different idling and back-pressure
    write_reg(lscemb_pkg::REG_BPC, 32'd1);
    write_reg(lscemb_pkg::REG_MSG_BITS, 32'd0);
    run_phase(120);
    idle_pct = 69;
    stall_pct = 0;
    run_phase(120);
    idle_pct = 0;
    stall_pct = 69;
    run_phase(120);
    idle_pct = 28;
    stall_pct = 28;
    run_phase(120);

    drain();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d words: %0d loads, %0d header, %0d data, %0d passthrough samples",
             words_sent, chk.loads, chk.hdr_cnt, chk.data_cnt, chk.pass_cnt);
    $display("with %0d register writes, settings 0 to 15, lengths up to 16383, %0d mismatches",
             reg_writes, chk.fails);
    if (chk.fails == 0) begin
      $display("** lsb_stego_channel_embedder_unit: PASSED **");
    end else begin
      $display("** lsb_stego_channel_embedder_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ----- lsb_stego_channel_embedder_unit.f -----
sv/lscemb_pkg.sv
sv/lscemb_front.sv
sv/lscemb_queue.sv
sv/lscemb_back.sv
sv/lsb_stego_channel_embedder_unit.sv
bench/lsb_stego_channel_embedder_unit_test.sv
